>>> src/trq_pkg.sv
// trq_pkg: shared types and constants for the timeline retirement queue.
// Used by trq_ctrl, trq_dp and timeline_retirement_queue. No dependencies.
`default_nettype none

package trq_pkg;

  // Default sizing
  localparam int DEPTH_DEF    = 64;
  localparam int TAG_BITS_DEF = 16;

  // Fixed field widths
  localparam int POINT_W = 64;
  localparam int MODE_W  = 2;
  localparam int CODE_W  = 2;

  // Command modes
  localparam logic [MODE_W-1:0] MODE_ENQ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

  // Result codes
  localparam logic [CODE_W-1:0] CODE_RETIRED = 2'd0;
  localparam logic [CODE_W-1:0] CODE_QUEUED  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_FULL    = 2'd2;
  localparam logic [CODE_W-1:0] CODE_NONE    = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } trq_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic enq;          // enqueue accepted this cycle
    logic start_drain;  // drain or flush accepted: latch operands
    logic pop;          // retire head entry
    logic emit_pend;    // send held retired tag
    logic emit_last;    // held tag is the final result
    logic emit_none;    // send "nothing retired" result
    logic finish;       // drain or flush done: settle pointers and max
  } trq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic head_ok;      // head entry exists and may retire
  } trq_stat_t;

endpackage

`default_nettype wire

>>> src/trq_ctrl.sv
// trq_ctrl: command sequencer for the timeline retirement queue.
// Depends on trq_pkg; drives trq_dp through trq_cmd_t.
`default_nettype none

module trq_ctrl
  import trq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire trq_stat_t         stat,
  output logic                   busy,
  output trq_cmd_t               cmd
);

  trq_state_t state_r, state_nxt;
  logic       have_pend_r, have_pend_nxt;

  assign busy = (state_r == ST_DRAIN);

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    have_pend_nxt = have_pend_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_mode)
            MODE_ENQ: cmd.enq = 1'b1;
            MODE_DRAIN, MODE_FLUSH: begin
              cmd.start_drain = 1'b1;
              have_pend_nxt   = 1'b0;
              state_nxt       = ST_DRAIN;
            end
            default: cmd.emit_none = 1'b1;
          endcase
        end
      end
      ST_DRAIN: begin
        if (stat.head_ok) begin
          // pop head; previously held tag is known not to be last
          cmd.pop       = 1'b1;
          cmd.emit_pend = have_pend_r;
          have_pend_nxt = 1'b1;
        end else begin
          cmd.finish    = 1'b1;
          cmd.emit_pend = have_pend_r;
          cmd.emit_last = have_pend_r;
          cmd.emit_none = !have_pend_r;
          have_pend_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_pend_r <= have_pend_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/trq_dp.sv
// trq_dp: queue storage, pointers, running maximum and result register.
// Depends on trq_pkg; commanded by trq_ctrl.
`default_nettype none

module trq_dp
  import trq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire trq_cmd_t                         cmd,
  input  wire logic [MODE_W-1:0]                in_mode,
  input  wire logic [POINT_W-1:0]               in_retire_point,
  input  wire logic [TAG_BITS-1:0]              in_task_tag,
  input  wire logic [POINT_W-1:0]               in_completed_value,
  output trq_stat_t                             stat,
  output logic                                  out_valid,
  output logic [TAG_BITS-1:0]                   out_tag_out,
  output logic [CODE_W-1:0]                     out_code,
  output logic [$clog2(DEPTH+1)-1:0]            out_retired_count,
  output logic                                  out_last
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  // Storage
  logic [TAG_BITS-1:0] tag_mem [DEPTH];
  logic [POINT_W-1:0]  pt_mem  [DEPTH];

  logic [PTR_W-1:0]    head_r, head_nxt, head_inc;
  logic [PTR_W-1:0]    tail_r, tail_nxt, tail_inc;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [POINT_W-1:0]  rmax_r, rmax_nxt;
  logic [POINT_W-1:0]  done_r;
  logic                flush_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TAG_BITS-1:0] pend_tag_r;
  logic [TAG_BITS-1:0] head_tag_r;
  logic [POINT_W-1:0]  head_pt_r;

  logic                imm_retire, full, we;
  logic [POINT_W-1:0]  eff_pt;

  logic                out_valid_r;
  logic [TAG_BITS-1:0] out_tag_r;
  logic [CODE_W-1:0]   out_code_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic                out_last_r;

  // Wrapping increments
  assign head_inc = (head_r == PTR_W'(DEPTH-1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == PTR_W'(DEPTH-1)) ? '0 : tail_r + 1'b1;

  // Enqueue decisions
  assign imm_retire = (in_retire_point <= in_completed_value);
  assign eff_pt     = (in_retire_point < rmax_r) ? rmax_r : in_retire_point;
  assign full       = (occ_r == CNT_W'(DEPTH));
  assign we         = cmd.enq && !imm_retire && !full;

  // Head entry may retire
  assign stat.head_ok = (occ_r != '0) && (flush_r || (head_pt_r <= done_r));

  // Pointer, occupancy and running max update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    rmax_nxt = rmax_r;
    if (we) begin
      tail_nxt = tail_inc;
      occ_nxt  = occ_r + 1'b1;
      rmax_nxt = eff_pt;
    end
    if (cmd.pop) begin
      head_nxt = head_inc;
      occ_nxt  = occ_r - 1'b1;
    end
    if (cmd.finish) begin
      if (flush_r) begin
        head_nxt = '0;
        tail_nxt = '0;
        occ_nxt  = '0;
        rmax_nxt = '0;
      end else if (occ_r == '0) begin
        rmax_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
      rmax_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
      rmax_r <= rmax_nxt;
    end
  end

  // Memory write; read port tracks the next head, write-first on collision
  always_ff @(posedge clk) begin
    if (we) begin
      tag_mem[tail_r] <= in_task_tag;
      pt_mem[tail_r]  <= eff_pt;
    end
    if (we && (tail_r == head_nxt)) begin
      head_tag_r <= in_task_tag;
      head_pt_r  <= eff_pt;
    end else begin
      head_tag_r <= tag_mem[head_nxt];
      head_pt_r  <= pt_mem[head_nxt];
    end
  end

  // Drain operands, retire count and held tag
  always_ff @(posedge clk) begin
    if (cmd.start_drain) begin
      done_r  <= in_completed_value;
      flush_r <= (in_mode == MODE_FLUSH);
      cnt_r   <= '0;
    end else if (cmd.pop) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.pop) begin
      pend_tag_r <= head_tag_r;
    end
  end

  // Result register: strobe reset, payload unreset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.enq || cmd.emit_pend || cmd.emit_none;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      out_tag_r  <= in_task_tag;
      out_code_r <= imm_retire ? CODE_RETIRED : (full ? CODE_FULL : CODE_QUEUED);
      out_cnt_r  <= imm_retire ? CNT_W'(1) : '0;
      out_last_r <= 1'b1;
    end else if (cmd.emit_pend) begin
      out_tag_r  <= pend_tag_r;
      out_code_r <= CODE_RETIRED;
      out_cnt_r  <= cmd.emit_last ? cnt_r : '0;
      out_last_r <= cmd.emit_last;
    end else if (cmd.emit_none) begin
      out_tag_r  <= '0;
      out_code_r <= CODE_NONE;
      out_cnt_r  <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tag_out       = out_tag_r;
  assign out_code          = out_code_r;
  assign out_retired_count = out_cnt_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

>>> src/timeline_retirement_queue.sv
// Timeline retirement queue: a FIFO of task tags ordered by retire point on a
// monotonic timeline. Results leave on out_* with out_valid high for exactly
// one cycle; the receiver cannot stall, so it must take every strobe. Enqueue
// and unused mode values answer in the cycle right after the command is taken
// and may be issued back to back (busy stays low). A drain or flush keeps busy
// high in ST_DRAIN until the head entry can no longer retire: the head entry is
// compared once per cycle as it comes out of the registered read port of the
// tag/point memory, so one tag is retired per cycle. Each retired tag is held
// in pend_tag_r and leaves through the result register on the next pop or on
// the finish, the last one carrying the count; with nothing to retire, the
// single result comes on the finish. Depends on trq_pkg, trq_ctrl, trq_dp.
`default_nettype none

module timeline_retirement_queue
  import trq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [MODE_W-1:0]             in_mode,
  input  wire logic [POINT_W-1:0]            in_retire_point,
  input  wire logic [TAG_BITS-1:0]           in_task_tag,
  input  wire logic [POINT_W-1:0]            in_completed_value,
  output logic                               out_valid,
  output logic [TAG_BITS-1:0]                out_tag_out,
  output logic [CODE_W-1:0]                  out_code,
  output logic [$clog2(DEPTH+1)-1:0]         out_retired_count,
  output logic                               out_last
);

  trq_cmd_t  cmd;
  trq_stat_t stat;

  // Sequencer
  trq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Storage and result path
  trq_dp #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_mode            (in_mode),
    .in_retire_point    (in_retire_point),
    .in_task_tag        (in_task_tag),
    .in_completed_value (in_completed_value),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_tag_out        (out_tag_out),
    .out_code           (out_code),
    .out_retired_count  (out_retired_count),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire
